@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

@@ hdl/pdpd_pkg.sv @@
// ---------------------------------------------------------------------------
// Parity deframer and prefix decoder package
// Widths, codes and types shared by the deframer, the code table and the top.
// ---------------------------------------------------------------------------
package pdpd_pkg;

  localparam int KIND_W        = 2;
  localparam int CHAR_W        = 8;
  localparam int CODE_W        = 16;
  localparam int LEN_W         = 5;
  localparam int SYM_W         = 8;
  localparam int MSG_W         = 16;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_BITS = 16;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int GROUP_SIZE    = 16;
  localparam int NUM_GROUPS    = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int FRAME_W       = 9;
  localparam int DATA_BITS     = 8;
  localparam int SHIFT_W       = 12;
  localparam int PEND_W        = 4;
  localparam int NIB_W         = 4;
  localparam int BIT_IDX_W     = $clog2(DATA_BITS);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;
  localparam logic [NIB_W-1:0]  ALPHA_ADJ = 4'd9;

  typedef struct packed {
    logic [CODE_W-1:0] pattern;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
  } pdpd_entry_t;

  typedef struct packed {
    logic              en;
    pdpd_entry_t       entry;
  } pdpd_load_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pdpd_query_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } pdpd_match_t;

  typedef struct packed {
    logic                 ok;
    logic [DATA_BITS-1:0] data;
  } pdpd_frame_t;

endpackage

@@ hdl/pdpd_intf.sv @@
// ---------------------------------------------------------------------------
// Parity deframer and prefix decoder channels
// Valid/ready channels for input items, result items and the register write.
// ---------------------------------------------------------------------------
interface pdpd_in_if;
  import pdpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] hex_char;
  logic [CODE_W-1:0] code_pattern;
  logic [LEN_W-1:0]  code_length;
  logic [SYM_W-1:0]  code_symbol;

  modport source (output valid, kind, hex_char, code_pattern, code_length, code_symbol,
                  input ready);
  modport sink (input valid, kind, hex_char, code_pattern, code_length, code_symbol,
                output ready);
endinterface

interface pdpd_out_if;
  import pdpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_in_run;
  logic             message_complete;

  modport source (output valid, symbol, last_in_run, message_complete, input ready);
  modport sink (input valid, symbol, last_in_run, message_complete, output ready);
endinterface

interface pdpd_cfg_if;
  import pdpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [MSG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hdl/parity_deframe_prefix_decoder.sv @@
// ---------------------------------------------------------------------------
// Parity deframer with prefix-code decoder
// Top level: item sequencing, partial code, symbol count and result output.
// ---------------------------------------------------------------------------
// A load or restart item, and a character that completes no frame or a frame
// with even parity, is handled in the idle state. A character that completes
// a frame with odd parity is accepted in idle; each of its eight data bits
// then passes a compare and an update state, and a flush state hands over the
// last symbol. Update and flush wait while the output register is not emptied.
// In the compare state every code table cell compares the partial code; a
// registered OR over the cell groups gives the symbol in the update state. A
// result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module parity_deframe_prefix_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdpd_in_if.sink    in_i,
  pdpd_cfg_if.sink   cfg_i,
  pdpd_out_if.source out_o
);
  import pdpd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic [CODE_W-1:0]    pcode_q, pcode_d;
  logic [LEN_W-1:0]     plen_q, plen_d;
  logic [MSG_W-1:0]     emitted_q, emitted_d;
  logic [MSG_W-1:0]     msg_q, msg_d;
  logic                 held_valid_q, held_valid_d;
  logic [SYM_W-1:0]     held_sym_q, held_sym_d;
  logic                 held_cmp_q, held_cmp_d;
  logic                 out_valid_q, out_valid_d;
  logic [SYM_W-1:0]     out_sym_q, out_sym_d;
  logic                 out_last_q, out_last_d;
  logic                 out_cmp_q, out_cmp_d;

  logic                 accept;
  logic                 restart;
  logic                 push;
  logic [CODE_W:0]      len_mask;
  pdpd_load_t           load;
  pdpd_query_t          query;
  pdpd_match_t          match;
  pdpd_frame_t          frame;
  logic                 cur_bit;
  logic                 emit;
  logic                 out_free;
  logic                 stall;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign restart     = accept && (in_i.kind == KIND_RESTART);
  assign push        = accept && (in_i.kind == KIND_CHAR);

  assign len_mask           = ((CODE_W+1)'(1) << in_i.code_length) - (CODE_W+1)'(1);
  assign load.en            = accept && (in_i.kind == KIND_LOAD) &&
                              (in_i.code_length != '0) &&
                              (in_i.code_length <= LEN_W'(MAX_CODE_BITS));
  assign load.entry.pattern = in_i.code_pattern & len_mask[CODE_W-1:0];
  assign load.entry.len     = in_i.code_length;
  assign load.entry.sym     = in_i.code_symbol;

  assign cur_bit    = data_q[BIT_IDX_W'(DATA_BITS - 1) - bit_idx_q];
  assign query.code = {pcode_q[CODE_W-2:0], cur_bit};
  assign query.len  = plen_q + LEN_W'(1);

  pdpd_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (restart),
    .push_i     (push),
    .hex_char_i (in_i.hex_char),
    .frame_o    (frame)
  );

  pdpd_row u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (restart),
    .load_i  (load),
    .query_i (query),
    .match_o (match)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = match.hit && (emitted_q < msg_q);
  assign stall    = emit && held_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    bit_idx_d    = bit_idx_q;
    data_d       = data_q;
    pcode_d      = pcode_q;
    plen_d       = plen_q;
    emitted_d    = emitted_q;
    msg_d        = msg_q;
    held_valid_d = held_valid_q;
    held_sym_d   = held_sym_q;
    held_cmp_d   = held_cmp_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    out_cmp_d    = out_cmp_q;

    if (cfg_i.valid && cfg_i.ready) begin
      msg_d = cfg_i.data;
    end

    case (state_q)
      ST_IDLE: begin
        if (restart) begin
          pcode_d   = '0;
          plen_d    = '0;
          emitted_d = '0;
        end else if (frame.ok) begin
          data_d    = frame.data;
          bit_idx_d = '0;
          state_d   = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!stall) begin
          if (match.hit || (query.len >= LEN_W'(MAX_CODE_BITS))) begin
            pcode_d = '0;
            plen_d  = '0;
          end else begin
            pcode_d = query.code;
            plen_d  = query.len;
          end
          if (emit) begin
            emitted_d = emitted_q + MSG_W'(1);
            if (held_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = held_sym_q;
              out_last_d  = 1'b0;
              out_cmp_d   = held_cmp_q;
            end
            held_valid_d = 1'b1;
            held_sym_d   = match.sym;
            held_cmp_d   = ((emitted_q + MSG_W'(1)) == msg_q);
          end
          bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
          state_d   = (bit_idx_q == BIT_IDX_W'(DATA_BITS - 1)) ? ST_FLUSH : ST_CMP;
        end
      end
      ST_FLUSH: begin
        if (!held_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = held_sym_q;
          out_last_d   = 1'b1;
          out_cmp_d    = held_cmp_q;
          held_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_idx_q    <= '0;
      pcode_q      <= '0;
      plen_q       <= '0;
      emitted_q    <= '0;
      msg_q        <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_idx_q    <= bit_idx_d;
      pcode_q      <= pcode_d;
      plen_q       <= plen_d;
      emitted_q    <= emitted_d;
      msg_q        <= msg_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    held_sym_q <= held_sym_d;
    held_cmp_q <= held_cmp_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_cmp_q  <= out_cmp_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.symbol           = out_sym_q;
  assign out_o.last_in_run      = out_last_q;
  assign out_o.message_complete = out_cmp_q;

  `ASSERT_PROP(a_idle_drained, (state_q == ST_IDLE) |-> !held_valid_q,
               "A symbol is still held back while the decoder is idle.")
  `ASSERT_PROP(a_plen_range, plen_q < LEN_W'(MAX_CODE_BITS),
               "The partial code length reached the longest code length.")
  `ASSERT_PROP(a_flush_entry,
               (state_q == ST_FLUSH) |-> ($past(state_q) == ST_UPD || $past(state_q) == ST_FLUSH),
               "The flush state was entered without finishing a frame.")

endmodule

@@ hdl/pdpd_cell.sv @@
// ---------------------------------------------------------------------------
// Code table cell
// Holds one code entry, shifts it to the next cell on a load and matches it.
// ---------------------------------------------------------------------------
module pdpd_cell (
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic                  active_i,
  input  pdpd_pkg::pdpd_entry_t load_i,
  input  pdpd_pkg::pdpd_entry_t entry_i,
  input  logic                  kill_i,
  output pdpd_pkg::pdpd_entry_t entry_o,
  output logic                  kill_o,
  input  pdpd_pkg::pdpd_query_t query_i,
  output logic                  hit_o,
  output logic [pdpd_pkg::SYM_W-1:0] sym_o
);
  import pdpd_pkg::*;

  pdpd_entry_t entry_q;
  logic        killed_q;
  logic        dup;

  // An older entry with the same code is shadowed by the one being loaded.
  assign dup     = active_i && (entry_q.len == load_i.len) &&
                   (entry_q.pattern == load_i.pattern);
  assign kill_o  = killed_q || dup;
  assign entry_o = entry_q;

  assign hit_o = active_i && !killed_q && (entry_q.len == query_i.len) &&
                 (entry_q.pattern == query_i.code);
  assign sym_o = hit_o ? entry_q.sym : '0;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q  <= entry_i;
      killed_q <= kill_i;
    end
  end

endmodule

@@ hdl/pdpd_row.sv @@
// ---------------------------------------------------------------------------
// Code table row
// Chain of table cells, fill count and a registered OR tree over the matches.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdpd_row (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  pdpd_pkg::pdpd_load_t  load_i,
  input  pdpd_pkg::pdpd_query_t query_i,
  output pdpd_pkg::pdpd_match_t match_o
);
  import pdpd_pkg::*;

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     shift;
  pdpd_entry_t              chain_entry [TABLE_ENTRIES+1];
  logic                     chain_kill  [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] hit;
  logic [SYM_W-1:0]         cell_sym    [TABLE_ENTRIES];
  logic [NUM_GROUPS-1:0]    grp_hit_q, grp_hit_d;
  logic [SYM_W-1:0]         grp_sym_q   [NUM_GROUPS];
  logic [SYM_W-1:0]         grp_sym_d   [NUM_GROUPS];
  logic [SYM_W-1:0]         sym_or;

  assign shift          = load_i.en && (count_q != CNT_W'(TABLE_ENTRIES));
  assign chain_entry[0] = load_i.entry;
  assign chain_kill[0]  = 1'b0;

  // The newest entry sits in the first cell, so the first count_q cells are live.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pdpd_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .active_i (CNT_W'(i) < count_q),
      .load_i   (load_i.entry),
      .entry_i  (chain_entry[i]),
      .kill_i   (chain_kill[i]),
      .entry_o  (chain_entry[i+1]),
      .kill_o   (chain_kill[i+1]),
      .query_i  (query_i),
      .hit_o    (hit[i]),
      .sym_o    (cell_sym[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (shift) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_sym_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < TABLE_ENTRIES) begin
          grp_hit_d[g] = grp_hit_d[g] | hit[g * GROUP_SIZE + k];
          grp_sym_d[g] = grp_sym_d[g] | cell_sym[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    sym_or = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sym_or = sym_or | grp_sym_q[g];
    end
  end

  assign match_o.hit = |grp_hit_q;
  assign match_o.sym = sym_or;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      grp_hit_q <= '0;
    end else begin
      count_q   <= count_d;
      grp_hit_q <= grp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_sym_q[g] <= grp_sym_d[g];
    end
  end

  `ASSERT_PROP(a_hit_unique, $onehot0(hit), "More than one table cell matches the query.")
  `ASSERT_PROP(a_count_range, count_q <= CNT_W'(TABLE_ENTRIES),
               "The table fill count exceeds the table size.")

endmodule

@@ hdl/pdpd_deframer.sv @@
// ---------------------------------------------------------------------------
// Nibble deframer
// Turns characters into nibbles, gathers 9-bit frames and checks odd parity.
// ---------------------------------------------------------------------------
module pdpd_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        push_i,
  input  logic [pdpd_pkg::CHAR_W-1:0] hex_char_i,
  output pdpd_pkg::pdpd_frame_t       frame_o
);
  import pdpd_pkg::*;

  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic               digit;
  logic [NIB_W-1:0]   nib;
  logic [SHIFT_W-1:0] fb;
  logic [PEND_W-1:0]  psum;
  logic [PEND_W-1:0]  rest;
  logic               has_frame;
  logic [SHIFT_W-1:0] window;
  logic [SHIFT_W-1:0] keep_mask;
  logic [FRAME_W-1:0] frame;

  assign digit     = (hex_char_i >= CHAR_ZERO) && (hex_char_i <= CHAR_NINE);
  assign nib       = digit ? hex_char_i[NIB_W-1:0] : hex_char_i[NIB_W-1:0] + ALPHA_ADJ;
  assign fb        = {shift_q[SHIFT_W-NIB_W-1:0], nib};
  assign psum      = pend_q + PEND_W'(NIB_W);
  assign has_frame = psum >= PEND_W'(FRAME_W);
  assign rest      = psum - PEND_W'(FRAME_W);
  assign window    = fb >> rest;
  assign frame     = window[FRAME_W-1:0];
  assign keep_mask = (SHIFT_W'(1) << rest) - SHIFT_W'(1);

  assign frame_o.ok   = push_i && has_frame && (^frame);
  assign frame_o.data = frame[FRAME_W-1:1];

  always_comb begin
    shift_d = shift_q;
    pend_d  = pend_q;
    if (clear_i) begin
      shift_d = '0;
      pend_d  = '0;
    end else if (push_i) begin
      if (has_frame) begin
        shift_d = fb & keep_mask;
        pend_d  = rest;
      end else begin
        shift_d = fb;
        pend_d  = psum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      pend_q  <= '0;
    end else begin
      shift_q <= shift_d;
      pend_q  <= pend_d;
    end
  end

endmodule
